// ===== src/obb_pkg.sv =====
// Package for the oriented-box to axis-aligned-box pipeline.
// Holds widths, register indexes, reset values and payload types.
// No dependencies; every other file imports it.
`default_nettype none

package obb_pkg;

	localparam int Q_W        = 16;  // Q7.8 input entry
	localparam int ROWS       = 3;   // rows of the world transform
	localparam int COLS       = 4;   // columns of the world transform
	localparam int AXES       = 3;   // box axes
	localparam int CFG_W      = 64;  // widest configuration register
	localparam int CFG_IDX_W  = 3;
	localparam int HALF_W     = 15;  // unsigned Q7.8 half extent
	localparam int MUL_W      = 32;  // Q7.8 x Q7.8 product
	localparam int PROD_W     = 34;  // sum of four products, Q.16
	localparam int MAG_W      = 33;  // magnitude of a matrix entry
	localparam int AXIS_W     = 48;  // |entry| x half extent, Q.24
	localparam int EXT_W      = 50;  // sum of three axis magnitudes
	localparam int ACC_W      = 52;  // corner bound, Q.24
	localparam int OUT_W      = 32;  // Q23.8 result
	localparam int CTR_SHIFT  = 8;   // Q.16 to Q.24
	localparam int FRAC_SHIFT = 16;  // Q.24 to Q.8
	localparam int PIPE_DEPTH = 6;   // register stages from input to output

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCAL_COL0 = 3'd0,
		REG_LOCAL_COL1 = 3'd1,
		REG_LOCAL_COL2 = 3'd2,
		REG_LOCAL_COL3 = 3'd3,
		REG_HALF_X     = 3'd4,
		REG_HALF_Y     = 3'd5,
		REG_HALF_Z     = 3'd6
	} reg_idx_t;

	localparam logic [CFG_W-1:0]  LOCAL_COL0_RST = 64'h0000_0000_0000_0100;
	localparam logic [CFG_W-1:0]  LOCAL_COL1_RST = 64'h0000_0000_0100_0000;
	localparam logic [CFG_W-1:0]  LOCAL_COL2_RST = 64'h0000_0100_0000_0000;
	localparam logic [CFG_W-1:0]  LOCAL_COL3_RST = 64'h0100_0000_0000_0000;
	localparam logic [HALF_W-1:0] HALF_RST       = 15'h0100;

	typedef logic [ROWS-1:0][COLS-1:0][Q_W-1:0] xform_t;

	typedef struct packed {
		logic [COLS-1:0][CFG_W-1:0]  local_col;
		logic [AXES-1:0][HALF_W-1:0] half;
	} obb_cfg_t;

	typedef logic [ROWS-1:0][COLS-1:0][PROD_W-1:0] prod_mat_t;
	typedef logic [ROWS-1:0][PROD_W-1:0]           ctr_vec_t;
	typedef logic [ROWS-1:0][EXT_W-1:0]            ext_vec_t;

	typedef struct packed {
		ctr_vec_t ctr;
		ext_vec_t ext;
	} span_t;

	typedef struct packed {
		logic [ROWS-1:0][OUT_W-1:0] lo;
		logic [ROWS-1:0][OUT_W-1:0] hi;
	} box_t;

endpackage

`default_nettype wire

// ===== src/obb_if.sv =====
// Stream interfaces: transform words in, bounding-box words out.
// Depends on obb_pkg for field widths.
`default_nettype none

interface obb_xf_if;
	import obb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] xform_r0_c0;
	logic signed [Q_W-1:0] xform_r0_c1;
	logic signed [Q_W-1:0] xform_r0_c2;
	logic signed [Q_W-1:0] xform_r0_c3;
	logic signed [Q_W-1:0] xform_r1_c0;
	logic signed [Q_W-1:0] xform_r1_c1;
	logic signed [Q_W-1:0] xform_r1_c2;
	logic signed [Q_W-1:0] xform_r1_c3;
	logic signed [Q_W-1:0] xform_r2_c0;
	logic signed [Q_W-1:0] xform_r2_c1;
	logic signed [Q_W-1:0] xform_r2_c2;
	logic signed [Q_W-1:0] xform_r2_c3;

	modport source (
		output valid,
		output xform_r0_c0, xform_r0_c1, xform_r0_c2, xform_r0_c3,
		output xform_r1_c0, xform_r1_c1, xform_r1_c2, xform_r1_c3,
		output xform_r2_c0, xform_r2_c1, xform_r2_c2, xform_r2_c3,
		input  ready
	);

	modport sink (
		input  valid,
		input  xform_r0_c0, xform_r0_c1, xform_r0_c2, xform_r0_c3,
		input  xform_r1_c0, xform_r1_c1, xform_r1_c2, xform_r1_c3,
		input  xform_r2_c0, xform_r2_c1, xform_r2_c2, xform_r2_c3,
		output ready
	);
endinterface

interface obb_box_if;
	import obb_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] min_x;
	logic signed [OUT_W-1:0] min_y;
	logic signed [OUT_W-1:0] min_z;
	logic signed [OUT_W-1:0] max_x;
	logic signed [OUT_W-1:0] max_y;
	logic signed [OUT_W-1:0] max_z;

	modport source (
		output valid,
		output min_x, min_y, min_z, max_x, max_y, max_z,
		input  ready
	);

	modport sink (
		input  valid,
		input  min_x, min_y, min_z, max_x, max_y, max_z,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/obb_mat.sv =====
// Matrix product stages: W (3x4) times the local 4x4 matrix, two register stages.
// Stage 1 registers the 48 entry products, stage 2 sums each group of four.
// Depends on obb_pkg.
`default_nettype none

module obb_mat (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_ready,
	input  wire obb_pkg::xform_t                            in_data,
	input  wire logic [obb_pkg::COLS-1:0][obb_pkg::CFG_W-1:0] local_col,
	output logic                                            out_valid,
	input  wire logic                                       out_ready,
	output obb_pkg::prod_mat_t                              out_data
);
	import obb_pkg::*;

	logic [ROWS-1:0][COLS-1:0][COLS-1:0][MUL_W-1:0] mul_s1;
	prod_mat_t                                      prod_s2;
	logic                                           v_s1;
	logic                                           v_s2;
	logic                                           en_s1;
	logic                                           en_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// mul_s1[r][c][k] = W[r][k] * L[k][c]
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					for (int k = 0; k < COLS; k++) begin
						mul_s1[r][c][k] <= $signed(in_data[r][k]) *
							$signed(local_col[c][Q_W*k +: Q_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					prod_s2[r][c] <= PROD_W'($signed(mul_s1[r][c][0])) +
						PROD_W'($signed(mul_s1[r][c][1])) +
						PROD_W'($signed(mul_s1[r][c][2])) +
						PROD_W'($signed(mul_s1[r][c][3]));
				end
			end
		end
	end

	assign out_valid = v_s2;
	assign out_data  = prod_s2;

endmodule

`default_nettype wire

// ===== src/obb_ext.sv =====
// Extent stages: scale axis columns by half extents and sum their magnitudes.
// Stage 3 multiplies |P[r][c]| by half_c, stage 4 adds the three axes per row.
// Depends on obb_pkg.
`default_nettype none

module obb_ext (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         in_valid,
	output logic                                              in_ready,
	input  wire obb_pkg::prod_mat_t                           in_data,
	input  wire logic [obb_pkg::AXES-1:0][obb_pkg::HALF_W-1:0] half,
	output logic                                              out_valid,
	input  wire logic                                         out_ready,
	output obb_pkg::span_t                                    out_data
);
	import obb_pkg::*;

	logic [ROWS-1:0][AXES-1:0][MAG_W-1:0]  mag;
	logic [ROWS-1:0][AXES-1:0][AXIS_W-1:0] axis_s3;
	ctr_vec_t                              ctr_s3;
	span_t                                 span_s4;
	logic                                  v_s3;
	logic                                  v_s4;
	logic                                  en_s3;
	logic                                  en_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Only the magnitude of each axis matters for the corner extremes.
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < AXES; c++) begin
				if (in_data[r][c][PROD_W-1]) begin
					mag[r][c] = MAG_W'(-$signed(in_data[r][c]));
				end else begin
					mag[r][c] = MAG_W'(in_data[r][c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			for (int r = 0; r < ROWS; r++) begin
				ctr_s3[r] <= in_data[r][COLS-1];
				for (int c = 0; c < AXES; c++) begin
					axis_s3[r][c] <= AXIS_W'(mag[r][c]) * AXIS_W'(half[c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			span_s4.ctr <= ctr_s3;
			for (int r = 0; r < ROWS; r++) begin
				span_s4.ext[r] <= EXT_W'(axis_s3[r][0]) + EXT_W'(axis_s3[r][1]) +
					EXT_W'(axis_s3[r][2]);
			end
		end
	end

	assign out_valid = v_s4;
	assign out_data  = span_s4;

endmodule

`default_nettype wire

// ===== src/obb_bound.sv =====
// Bound stages: center minus/plus extent, then round to Q.8 and saturate.
// Stage 6 is the output register seen on the result channel.
// Depends on obb_pkg.
`default_nettype none

module obb_bound (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire obb_pkg::span_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output obb_pkg::box_t       out_data
);
	import obb_pkg::*;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd32768);
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-64'sd2147483648);

	logic signed [ROWS-1:0][ACC_W-1:0] lo_s5;
	logic signed [ROWS-1:0][ACC_W-1:0] hi_s5;
	box_t                              box_s6;
	box_t                              box_d;
	logic                              v_s5;
	logic                              v_s6;
	logic                              en_s5;
	logic                              en_s6;

	function automatic logic [OUT_W-1:0] round_sat(input logic [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = ($signed(v) + RND_HALF) >>> FRAC_SHIFT;
		if (r > SAT_HI) begin
			return SAT_HI[OUT_W-1:0];
		end else if (r < SAT_LO) begin
			return SAT_LO[OUT_W-1:0];
		end
		return r[OUT_W-1:0];
	endfunction

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			for (int r = 0; r < ROWS; r++) begin
				lo_s5[r] <= (ACC_W'($signed(in_data.ctr[r])) <<< CTR_SHIFT) -
					$signed(ACC_W'(in_data.ext[r]));
				hi_s5[r] <= (ACC_W'($signed(in_data.ctr[r])) <<< CTR_SHIFT) +
					$signed(ACC_W'(in_data.ext[r]));
			end
		end
	end

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			box_d.lo[r] = round_sat(lo_s5[r]);
			box_d.hi[r] = round_sat(hi_s5[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && v_s5) begin
			box_s6 <= box_d;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = box_s6;

endmodule

`default_nettype wire

// ===== src/oriented_box_to_aabb.sv =====
// Top level of the oriented-box to axis-aligned bounding-box pipeline.
// Depends on obb_pkg, obb_if, obb_mat, obb_ext and obb_bound.
`default_nettype none

// Each transform word (upper three rows of a world matrix, signed Q7.8) is
// multiplied by the configured local matrix; column 3 of the product is the
// box center and columns 0..2, scaled by the half extents, are the box axes.
// The result word is the enclosing axis-aligned box, min and max per axis in
// signed Q23.8, rounded to nearest (ties up) and saturated to 32 bits.
// Throughput is one word per clock while the result channel is not stalled.
// The word passes six register stages, and the accepting edge loads the
// first. The stages: two for the matrix product (products, then four-term
// sums), two for the extents (magnitude times half extent, then a three-term
// sum), one for center minus/plus extent and one for round/saturate, which
// is also the output register. Every stage carries its own valid bit and
// ready is computed per stage, so a stalled result only blocks the stages
// behind it once they are full; bubbles are squeezed out.
// Configuration writes take effect on the next cycle and are meant to happen
// while no word is in flight; reset loads the identity matrix and unit half
// extents. Writes to register index 7 are ignored.

module oriented_box_to_aabb (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [obb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [obb_pkg::CFG_W-1:0]     cfg_wdata,
	obb_xf_if.sink                             xf,
	obb_box_if.source                          box
);
	import obb_pkg::*;

	obb_cfg_t  cfg_q;
	xform_t    xf_data;
	prod_mat_t mat_data;
	logic      mat_valid;
	logic      mat_ready;
	span_t     ext_data;
	logic      ext_valid;
	logic      ext_ready;
	box_t      box_data;

	// Register file: hold the local matrix columns and the half extents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_col[0] <= LOCAL_COL0_RST;
			cfg_q.local_col[1] <= LOCAL_COL1_RST;
			cfg_q.local_col[2] <= LOCAL_COL2_RST;
			cfg_q.local_col[3] <= LOCAL_COL3_RST;
			cfg_q.half[0]      <= HALF_RST;
			cfg_q.half[1]      <= HALF_RST;
			cfg_q.half[2]      <= HALF_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_LOCAL_COL0: cfg_q.local_col[0] <= cfg_wdata;
				REG_LOCAL_COL1: cfg_q.local_col[1] <= cfg_wdata;
				REG_LOCAL_COL2: cfg_q.local_col[2] <= cfg_wdata;
				REG_LOCAL_COL3: cfg_q.local_col[3] <= cfg_wdata;
				REG_HALF_X:     cfg_q.half[0]      <= cfg_wdata[HALF_W-1:0];
				REG_HALF_Y:     cfg_q.half[1]      <= cfg_wdata[HALF_W-1:0];
				REG_HALF_Z:     cfg_q.half[2]      <= cfg_wdata[HALF_W-1:0];
				default: begin
					// drop writes to the unused index
				end
			endcase
		end
	end

	// Gather the transform fields into a row/column array.
	assign xf_data[0][0] = xf.xform_r0_c0;
	assign xf_data[0][1] = xf.xform_r0_c1;
	assign xf_data[0][2] = xf.xform_r0_c2;
	assign xf_data[0][3] = xf.xform_r0_c3;
	assign xf_data[1][0] = xf.xform_r1_c0;
	assign xf_data[1][1] = xf.xform_r1_c1;
	assign xf_data[1][2] = xf.xform_r1_c2;
	assign xf_data[1][3] = xf.xform_r1_c3;
	assign xf_data[2][0] = xf.xform_r2_c0;
	assign xf_data[2][1] = xf.xform_r2_c1;
	assign xf_data[2][2] = xf.xform_r2_c2;
	assign xf_data[2][3] = xf.xform_r2_c3;

	// Stages 1-2: P = W * L.
	obb_mat u_mat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xf.valid),
		.in_ready  (xf.ready),
		.in_data   (xf_data),
		.local_col (cfg_q.local_col),
		.out_valid (mat_valid),
		.out_ready (mat_ready),
		.out_data  (mat_data)
	);

	// Stages 3-4: center and summed axis magnitudes per row.
	obb_ext u_ext (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat_valid),
		.in_ready  (mat_ready),
		.in_data   (mat_data),
		.half      (cfg_q.half),
		.out_valid (ext_valid),
		.out_ready (ext_ready),
		.out_data  (ext_data)
	);

	// Stages 5-6: bounds, rounding, saturation, output register.
	obb_bound u_bound (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ext_valid),
		.in_ready  (ext_ready),
		.in_data   (ext_data),
		.out_valid (box.valid),
		.out_ready (box.ready),
		.out_data  (box_data)
	);

	assign box.min_x = box_data.lo[0];
	assign box.min_y = box_data.lo[1];
	assign box.min_z = box_data.lo[2];
	assign box.max_x = box_data.hi[0];
	assign box.max_y = box_data.hi[1];
	assign box.max_z = box_data.hi[2];

endmodule

`default_nettype wire

// ===== src/obb_chk.sv =====
// Port-level checker for oriented_box_to_aabb, attached by bind.
// Tracks words in flight and checks occupancy and output-hold behavior.
// Depends on obb_pkg.
`default_nettype none

module obb_chk (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [6*obb_pkg::OUT_W-1:0]    out_box
);
	import obb_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

	logic [CNT_W-1:0] inflight_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	// An empty output register must never block the input side.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	// No result without a word in flight.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> !out_valid)
		else $error("result shown with no word in flight");

	// The pipeline never holds more words than it has stages.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_box))
		else $error("stalled result changed or dropped");

endmodule

bind oriented_box_to_aabb obb_chk u_obb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (xf.valid),
	.in_ready  (xf.ready),
	.out_valid (box.valid),
	.out_ready (box.ready),
	.out_box   ({box.min_x, box.min_y, box.min_z, box.max_x, box.max_y, box.max_z})
);

`default_nettype wire
